### sv/fdl_pkg.sv
// ----------------------------------------------------------------------------
// fdl_pkg
// Shared types and constants of the feedback delay line.
// ----------------------------------------------------------------------------
`default_nettype none

package fdl_pkg;

  localparam int unsigned PADDR_W = 4;

  // register map, one word per register
  typedef enum logic [1:0] {
    REG_TARGET_DELAY  = 2'd0,
    REG_FEEDBACK_GAIN = 2'd1,
    REG_WET_MIX       = 2'd2,
    REG_SMOOTH_RATE   = 2'd3
  } fdl_reg_idx_t;

  typedef struct packed {
    logic [23:0] target_delay;
    logic [14:0] feedback_gain;
    logic [15:0] wet_mix;
    logic [15:0] smooth_rate;
  } fdl_cfg_t;

  localparam logic [23:0] TARGET_DELAY_RST  = 24'd0;
  localparam logic [14:0] FEEDBACK_GAIN_RST = 15'd0;
  localparam logic [15:0] WET_MIX_RST       = 16'd16384;
  localparam logic [15:0] SMOOTH_RATE_RST   = 16'd64;

  localparam logic [14:0] FEEDBACK_CAP = 15'd32604;
  localparam logic [15:0] MIX_UNITY    = 16'd32768;

  localparam logic [23:0] S24_MAX = 24'h7FFFFF;
  localparam logic [23:0] S24_MIN = 24'h800000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SMOOTH,
    ST_ADDR,
    ST_READ,
    ST_INTERP,
    ST_DELAY,
    ST_MIX,
    ST_DONE
  } fdl_state_t;

endpackage

`default_nettype wire

### sv/fdl_cfg.sv
// ----------------------------------------------------------------------------
// fdl_cfg
// APB register file: target delay, feedback gain, wet mix, smoothing rate.
// ----------------------------------------------------------------------------
`default_nettype none

module fdl_cfg
  import fdl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready,
  output      fdl_cfg_t           cfg
);

  fdl_cfg_t     cfg_r;
  fdl_reg_idx_t reg_idx;
  logic         wr_en;

  assign pready  = 1'b1;
  assign reg_idx = fdl_reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_delay  <= TARGET_DELAY_RST;
      cfg_r.feedback_gain <= FEEDBACK_GAIN_RST;
      cfg_r.wet_mix       <= WET_MIX_RST;
      cfg_r.smooth_rate   <= SMOOTH_RATE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TARGET_DELAY:  cfg_r.target_delay  <= pwdata[23:0];
        REG_FEEDBACK_GAIN: cfg_r.feedback_gain <= pwdata[14:0];
        REG_WET_MIX:       cfg_r.wet_mix       <= pwdata[15:0];
        REG_SMOOTH_RATE:   cfg_r.smooth_rate   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_TARGET_DELAY:  prdata = {8'd0, cfg_r.target_delay};
      REG_FEEDBACK_GAIN: prdata = {17'd0, cfg_r.feedback_gain};
      REG_WET_MIX:       prdata = {16'd0, cfg_r.wet_mix};
      REG_SMOOTH_RATE:   prdata = {16'd0, cfg_r.smooth_rate};
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### sv/fdl_store.sv
// ----------------------------------------------------------------------------
// fdl_store
// Circular sample store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module fdl_store
  import fdl_pkg::*;
#(
  parameter int DELAY_DEPTH = 65536
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           rd_en,
  input  wire logic [$clog2(DELAY_DEPTH)-1:0] rd_addr0,
  input  wire logic [$clog2(DELAY_DEPTH)-1:0] rd_addr1,
  output      logic [23:0]                    rd_data0,
  output      logic [23:0]                    rd_data1,
  input  wire logic                           wr_en,
  input  wire logic [$clog2(DELAY_DEPTH)-1:0] wr_addr,
  input  wire logic [23:0]                    wr_data
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam logic [AW-1:0] ADDR_LAST = AW'(DELAY_DEPTH - 1);

  logic [23:0]   mem [DELAY_DEPTH];
  logic [23:0]   q0_r, q1_r;
  logic          ok0_r, ok1_r;
  // writes go in address order from zero, so the fill count marks
  // which entries hold data; the rest read as the cleared value
  logic [AW-1:0] fill_r;
  logic          full_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q0_r  <= mem[rd_addr0];
      q1_r  <= mem[rd_addr1];
      ok0_r <= full_r || (rd_addr0 < fill_r);
      ok1_r <= full_r || (rd_addr1 < fill_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      full_r <= 1'b0;
    end else if (wr_en && !full_r) begin
      if (fill_r == ADDR_LAST) begin
        full_r <= 1'b1;
      end else begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  assign rd_data0 = ok0_r ? q0_r : '0;
  assign rd_data1 = ok1_r ? q1_r : '0;

endmodule

`default_nettype wire

### sv/feedback_delay_line.sv
// ----------------------------------------------------------------------------
// feedback_delay_line
// Fractional feedback delay with smoothed length and linear interpolation.
// ----------------------------------------------------------------------------
// One sample is in flight at a time: the delay-length smoothing, read
// address, store read, interpolation, mix products and saturation/write-back
// run one after another through a single datapath around the sample store.
// The store is DELAY_DEPTH x 24 bits with two registered read ports; entries
// not yet written since reset read as zero through a fill count, so the
// block is ready right after reset with no clearing pass. A finished result
// sits in the output register while the next sample is already accepted;
// the write-back of that next sample waits only if the earlier result is
// still held by out_stall. Registers are to be written while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module feedback_delay_line
  import fdl_pkg::*;
#(
  parameter int DELAY_DEPTH = 65536
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [23:0]        in_sample_in,
  input  wire logic               in_end_of_block,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic [23:0]        out_sample_out,
  output      logic               out_block_last,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int SW = AW + 16;  // smoothed delay, AW.16
  localparam logic [AW-1:0] IDX_LAST = AW'(DELAY_DEPTH - 1);
  localparam logic [31:0]   TMAX     = 32'((DELAY_DEPTH - 1) * 256);
  localparam logic [SW:0]   POS_WRAP = (SW + 1)'(DELAY_DEPTH) << 16;

  function automatic logic [23:0] sat24(input logic [26:0] v);
    logic [23:0] r;
    if (!v[26] && (v[25:23] != 3'b000)) begin
      r = S24_MAX;
    end else if (v[26] && (v[25:23] != 3'b111)) begin
      r = S24_MIN;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  fdl_cfg_t cfg;

  fdl_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fdl_state_t state_r, state_nxt;

  logic signed [23:0]    x_r;
  logic                  last_r;
  logic signed [SW+16:0] sprod_r;
  logic [SW-1:0]         sm_r;
  logic [AW-1:0]         wi_r;
  logic [AW-1:0]         i0_r, i1_r;
  logic [15:0]           frac_r;
  logic signed [41:0]    iprod_r;
  logic signed [23:0]    delayed_r;
  logic signed [40:0]    px_r, pd_r;
  logic signed [39:0]    pf_r;
  logic                  out_valid_r;
  logic [23:0]           out_sample_r;
  logic                  out_last_r;

  logic                  accept, out_free, done_fire, rd_en;
  logic [31:0]           t8;
  logic [SW-1:0]         t16;
  logic signed [SW:0]    sdiff;
  logic signed [SW+16:0] sprod;
  logic signed [SW:0]    sstep;
  logic signed [SW+1:0]  ssum;
  logic [SW-1:0]         sm_new;
  logic [SW:0]           pos_raw, pos;
  logic [AW-1:0]         pos_i0, pos_i1;
  logic [23:0]           rd_data0, rd_data1;
  logic signed [24:0]    sdelta;
  logic signed [41:0]    iprod;
  logic signed [25:0]    dsum;
  logic [15:0]           wet_eff, dry_eff;
  logic [14:0]           fb_eff;
  logic signed [41:0]    msum;
  logic signed [25:0]    wsum;
  logic [23:0]           y_sat, w_sat;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign done_fire = (state_r == ST_DONE) && out_free;

  // delay length smoothing
  assign t8     = ({8'd0, cfg.target_delay} > TMAX) ? TMAX : {8'd0, cfg.target_delay};
  assign t16    = {t8[AW+7:0], 8'd0};
  assign sdiff  = $signed({1'b0, t16}) - $signed({1'b0, sm_r});
  assign sprod  = sdiff * $signed({1'b0, cfg.smooth_rate});
  assign sstep  = sprod_r[SW+16:16];
  assign ssum   = $signed({2'b00, sm_r}) + $signed({sstep[SW], sstep});
  assign sm_new = ssum[SW+1] ? '0 : ssum[SW-1:0];

  // read position behind the write index, wrapped into the store
  assign pos_raw = {1'b0, wi_r, 16'd0} - {1'b0, sm_r};
  assign pos     = pos_raw[SW] ? (pos_raw + POS_WRAP) : pos_raw;
  assign pos_i0  = pos[SW-1:16];
  assign pos_i1  = (pos_i0 == IDX_LAST) ? '0 : (pos_i0 + 1'b1);

  // interpolation
  assign sdelta = $signed({rd_data1[23], rd_data1}) - $signed({rd_data0[23], rd_data0});
  assign iprod  = sdelta * $signed({1'b0, frac_r});
  assign dsum   = $signed({{2{rd_data0[23]}}, rd_data0}) + iprod_r[41:16];

  // mix and feedback gains
  assign wet_eff = (cfg.wet_mix > MIX_UNITY) ? MIX_UNITY : cfg.wet_mix;
  assign dry_eff = MIX_UNITY - wet_eff;
  assign fb_eff  = (cfg.feedback_gain > FEEDBACK_CAP) ? FEEDBACK_CAP : cfg.feedback_gain;

  assign msum  = $signed({px_r[40], px_r}) + $signed({pd_r[40], pd_r});
  assign wsum  = $signed({{2{x_r[23]}}, x_r}) + $signed({pf_r[39], pf_r[39:15]});
  assign y_sat = sat24(msum[41:15]);
  assign w_sat = sat24({wsum[25], wsum});

  fdl_store #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr0 (i0_r),
    .rd_addr1 (i1_r),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1),
    .wr_en    (done_fire),
    .wr_addr  (wi_r),
    .wr_data  (w_sat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    unique case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_SMOOTH;
      ST_SMOOTH: state_nxt = ST_ADDR;
      ST_ADDR:   state_nxt = ST_READ;
      ST_READ: begin
        rd_en     = 1'b1;
        state_nxt = ST_INTERP;
      end
      ST_INTERP: state_nxt = ST_DELAY;
      ST_DELAY:  state_nxt = ST_MIX;
      ST_MIX:    state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control state: smoothed delay, write index, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sm_r        <= '0;
      wi_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_SMOOTH) begin
        sm_r <= sm_new;
      end
      if (done_fire) begin
        wi_r        <= (wi_r == IDX_LAST) ? '0 : (wi_r + 1'b1);
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r     <= $signed(in_sample_in);
      last_r  <= in_end_of_block;
      sprod_r <= sprod;
    end
    if (state_r == ST_ADDR) begin
      i0_r   <= pos_i0;
      i1_r   <= pos_i1;
      frac_r <= pos[15:0];
    end
    if (state_r == ST_INTERP) begin
      iprod_r <= iprod;
    end
    if (state_r == ST_DELAY) begin
      delayed_r <= dsum[23:0];
    end
    if (state_r == ST_MIX) begin
      px_r <= x_r * $signed({1'b0, dry_eff});
      pd_r <= delayed_r * $signed({1'b0, wet_eff});
      pf_r <= delayed_r * $signed({1'b0, fb_eff});
    end
    if (done_fire) begin
      out_sample_r <= y_sat;
      out_last_r   <= last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_block_last = out_last_r;

endmodule

`default_nettype wire

### sv/fdl_checker.sv
// ----------------------------------------------------------------------------
// fdl_checker
// Port-level checks of the feedback delay line, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fdl_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [23:0] out_sample_out,
  input wire logic        out_block_last
);

  // no result pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one sample in flight: the input stalls after each transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a sample is in flight");

  // a result cannot appear the cycle right after its input transfer
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result too early");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_sample_out) && $stable(out_block_last))
    else $error("stalled result changed");

endmodule

bind feedback_delay_line fdl_checker u_fdl_checker (.*);

`default_nettype wire
